/* src/pdq_pkg.sv */
// shared constants for the phase to dq current transform
// rotation angle table, fixed point scale factors and result word layout
// no dependencies
package pdq_pkg;

  // rotation chain
  localparam int STEPS = 24;

  // atan(2^-i) as a 32-bit fraction of a full turn
  localparam logic [31:0] ATAN_TURN [0:STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic [31:0] QUARTER_TURN = 32'h40000000;

  // alpha and beta carry 12 fraction bits
  localparam int FRAC_BITS = 12;

  // 4096/3 = 1365 + 1/3, the remainder goes through the divide by three
  localparam logic [10:0] ALPHA_MUL = 11'd1365;

  // 2^16/3 = 21845 + 1/3, for the high part of the split operand
  localparam logic [15:0] HI_DIV3_MUL = 16'd21845;

  // divide by three of a 22-bit value: offset to non-negative, then reciprocal
  localparam int          DIV3_W      = 22;
  localparam logic [21:0] DIV3_OFFSET = 22'd1572864;  // 3 * 2^19
  localparam logic [21:0] RECIP3      = 22'd2796203;  // ceil(2^23 / 3)
  localparam int          RECIP3_SH   = 23;

  // round(2^28 / sqrt3)
  localparam logic [27:0] INV_SQRT3_Q28 = 28'd154981283;

  // operands are split into a signed high part and a 16-bit low part
  localparam int SPLIT_W = 36;
  localparam int LO_W    = 16;

  // rotation gain correction, Q16
  localparam logic [15:0] CORDIC_GAIN_Q16 = 16'd39797;
  localparam int          GAIN_SH         = 28;

  // result word
  localparam int                  OUT_W       = 18;
  localparam logic signed [17:0]  OUT_MAX     = 18'sh1FFFF;
  localparam logic signed [17:0]  OUT_MIN     = 18'sh20000;
  localparam int                  OUT_TDATA_W = 40;

endpackage

/* src/pdq_clarke.sv */
// clarke front end: phase currents to alpha/beta with 12 fraction bits,
// angle to a 32-bit turn fraction and half-turn pre-rotation, four stages
// depends on pdq_pkg
module pdq_clarke #(
  parameter int CB = 16,
  parameter int AB = 16,
  parameter int XW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CB-1:0] phase_a,
  input  logic signed [CB-1:0] phase_b,
  input  logic signed [CB-1:0] phase_c,
  input  logic        [AB-1:0] elec_angle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic        [31:0]   z_out
);
  import pdq_pkg::*;

  localparam int VW = CB + 2;

  // stage advance, bubbles collapse
  logic adv1, adv2, adv3, adv4;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  assign adv4     = !s4_v_r || out_ready;
  assign adv3     = !s3_v_r || adv4;
  assign adv2     = !s2_v_r || adv3;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_valid;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
      if (adv4) s4_v_r <= s3_v_r;
    end
  end

  // stage 1: sums of phases, mode select, angle to turn fraction
  logic signed [VW-1:0] dv_nxt, num_nxt;
  logic                 two_nxt;
  logic        [31:0]   z1_nxt;
  logic signed [CB-1:0] s1_a_r;
  logic signed [VW-1:0] s1_dv_r, s1_num_r;
  logic                 s1_two_r;
  logic        [31:0]   s1_z_r;

  always_comb begin
    two_nxt = (phase_c == '0);
    dv_nxt  = (VW'(phase_a) <<< 1) - VW'(phase_b) - VW'(phase_c);
    if (two_nxt) begin
      num_nxt = VW'(phase_a) + (VW'(phase_b) <<< 1);
    end else begin
      num_nxt = VW'(phase_b) - VW'(phase_c);
    end
    // rotation runs by minus the angle
    z1_nxt = 32'd0 - {elec_angle, {(32-AB){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_a_r   <= phase_a;
      s1_dv_r  <= dv_nxt;
      s1_num_r <= num_nxt;
      s1_two_r <= two_nxt;
      s1_z_r   <= z1_nxt;
    end
  end

  // stage 2: constant products on split operands
  logic signed [SPLIT_W-1:0]    w_ext, n_ext;
  logic signed [SPLIT_W-LO_W-1:0] w_hi, n_hi;
  logic        [LO_W-1:0]       w_lo, n_lo;
  logic signed [DIV3_W-1:0]     s_nxt;
  logic signed [VW+11:0]        p1_full;
  logic signed [SPLIT_W-LO_W+16:0] hi3_full;
  logic signed [47:0]           bhi_full;
  logic        [44:0]           blo_prod;
  logic signed [XW-1:0]         p1_nxt, bhi_nxt;

  logic signed [CB-1:0]     s2_a_r;
  logic                     s2_two_r;
  logic        [31:0]       s2_z_r;
  logic signed [DIV3_W-1:0] s2_s_r;
  logic signed [XW-1:0]     s2_p1_r, s2_bhi_r;
  logic        [28:0]       s2_blo_r;

  always_comb begin
    // (4096*v + 1)/3 = 1365*v + (v + 1)/3, and (v + 1) = hi*2^16 + lo,
    // so (v + 1)/3 = 21845*hi + (hi + lo)/3
    w_ext    = SPLIT_W'(s1_dv_r) + SPLIT_W'(1);
    w_hi     = w_ext[SPLIT_W-1:LO_W];
    w_lo     = w_ext[LO_W-1:0];
    s_nxt    = DIV3_W'(w_hi) + $signed({{(DIV3_W-LO_W){1'b0}}, w_lo});
    p1_full  = s1_dv_r * $signed({1'b0, ALPHA_MUL});
    hi3_full = w_hi * $signed({1'b0, HI_DIV3_MUL});
    p1_nxt   = XW'(p1_full) + XW'(hi3_full);
    // beta = hi*k + round(lo*k / 2^16)
    n_ext    = SPLIT_W'(s1_num_r);
    n_hi     = n_ext[SPLIT_W-1:LO_W];
    n_lo     = n_ext[LO_W-1:0];
    bhi_full = n_hi * $signed({1'b0, INV_SQRT3_Q28});
    bhi_nxt  = XW'(bhi_full);
    blo_prod = 45'(n_lo) * 45'(INV_SQRT3_Q28) + 45'd32768;
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      s2_a_r   <= s1_a_r;
      s2_two_r <= s1_two_r;
      s2_z_r   <= s1_z_r;
      s2_s_r   <= s_nxt;
      s2_p1_r  <= p1_nxt;
      s2_bhi_r <= bhi_nxt;
      s2_blo_r <= blo_prod[44:16];
    end
  end

  // stage 3: finish the divide by three, form alpha and beta
  logic        [DIV3_W-1:0]   s_off;
  logic        [2*DIV3_W-1:0] q_prod;
  logic signed [DIV3_W-1:0]   q3;
  logic signed [XW-1:0]       alpha_nxt, beta_nxt;
  logic signed [XW-1:0]       s3_x_r, s3_y_r;
  logic        [31:0]         s3_z_r;

  always_comb begin
    s_off  = $unsigned(s2_s_r) + DIV3_OFFSET;
    q_prod = (2*DIV3_W)'(s_off) * (2*DIV3_W)'(RECIP3);
    q3     = $signed({1'b0, q_prod[2*DIV3_W-2:RECIP3_SH]}) - DIV3_W'(524288);
    if (s2_two_r) begin
      alpha_nxt = XW'(s2_a_r) <<< FRAC_BITS;
    end else begin
      alpha_nxt = s2_p1_r + XW'(q3);
    end
    beta_nxt = s2_bhi_r + XW'($signed({1'b0, s2_blo_r}));
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_v_r) begin
      s3_x_r <= alpha_nxt;
      s3_y_r <= beta_nxt;
      s3_z_r <= s2_z_r;
    end
  end

  // stage 4: half-turn pre-rotation for angles in the left half plane
  logic [31:0] zq;
  logic        flip;
  logic signed [XW-1:0] s4_x_r, s4_y_r;
  logic        [31:0]   s4_z_r;

  always_comb begin
    zq   = s3_z_r + QUARTER_TURN;
    flip = zq[31];
  end

  always_ff @(posedge clk) begin
    if (adv4 && s3_v_r) begin
      s4_x_r <= flip ? -s3_x_r : s3_x_r;
      s4_y_r <= flip ? -s3_y_r : s3_y_r;
      s4_z_r <= {s3_z_r[31] ^ flip, s3_z_r[30:0]};
    end
  end

  assign out_valid = s4_v_r;
  assign x_out     = s4_x_r;
  assign y_out     = s4_y_r;
  assign z_out     = s4_z_r;

endmodule

/* src/pdq_cordic_cell.sv */
// one rotation step of the angle chain: shift, add/subtract, angle update
// depends on pdq_pkg for the angle table
module pdq_cordic_cell #(
  parameter int XW   = 32,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic        [31:0]   z_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic        [31:0]   z_out
);
  import pdq_pkg::*;

  logic                 adv;
  logic                 v_r;
  logic signed [XW-1:0] xs, ys, x_nxt, y_nxt, x_r, y_r;
  logic        [31:0]   z_nxt, z_r;

  assign adv      = !v_r || out_ready;
  assign in_ready = adv;

  // rotate toward zero residual angle
  always_comb begin
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
    if (!z_in[31]) begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN_TURN[STEP];
    end else begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN_TURN[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign out_valid = v_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;

endmodule

/* src/pdq_scale.sv */
// gain correction, rounding and saturation to 18-bit d/q, output register
// depends on pdq_pkg
module pdq_scale #(
  parameter int XW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [XW-1:0]      x_in,
  input  logic signed [XW-1:0]      y_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [pdq_pkg::OUT_W-1:0] current_d,
  output logic signed [pdq_pkg::OUT_W-1:0] current_q
);
  import pdq_pkg::*;

  localparam int PW = XW + 17;
  localparam logic signed [PW-1:0] RND_HALF = PW'(2**(GAIN_SH-1));
  localparam logic signed [PW-1:0] SAT_HI   = PW'(OUT_MAX);
  localparam logic signed [PW-1:0] SAT_LO   = PW'(OUT_MIN);

  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + RND_HALF) >>> GAIN_SH;
    if (r > SAT_HI) begin
      return OUT_MAX;
    end else if (r < SAT_LO) begin
      return OUT_MIN;
    end
    return OUT_W'(r);
  endfunction

  logic adv_a, adv_b;
  logic va_r, vb_r;
  logic signed [PW-1:0]    px_nxt, py_nxt, px_r, py_r;
  logic signed [OUT_W-1:0] d_r, q_r;

  assign adv_b    = !vb_r || out_ready;
  assign adv_a    = !va_r || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= in_valid;
      if (adv_b) vb_r <= va_r;
    end
  end

  // gain products
  assign px_nxt = x_in * $signed({1'b0, CORDIC_GAIN_Q16});
  assign py_nxt = y_in * $signed({1'b0, CORDIC_GAIN_Q16});

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
  end

  // round, clamp, hold until taken
  always_ff @(posedge clk) begin
    if (adv_b && va_r) begin
      d_r <= round_sat(px_r);
      q_r <= round_sat(py_r);
    end
  end

  assign out_valid = vb_r;
  assign current_d = d_r;
  assign current_q = q_r;

endmodule

/* src/phase_to_dq_current.sv */
// channel | dir | ports                        | word
// in      | in  | in_tvalid/in_tready/in_tdata | phase_a, phase_b, phase_c, elec_angle
// out     | out | out_tvalid/out_tready/out_tdata | current_d, current_q
//
// one word per cycle in and out while out_tready is high; 4 clarke stages,
// 24 rotation cells, 2 gain/saturation stages
// every stage holds its own valid bit and fills when empty, so bubbles close up
// and input is taken while a result waits, as long as some stage is empty
// rst_n is synchronous, active low, and clears the valid bits only
// depends on pdq_pkg, pdq_clarke, pdq_cordic_cell, pdq_scale
module phase_to_dq_current #(
  parameter int CURRENT_BITS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // phase_a, phase_b, phase_c (CURRENT_BITS each), elec_angle (ANGLE_BITS), zero pad
  input  logic [((3*CURRENT_BITS+ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // current_d [17:0], current_q [35:18], zero pad
  output logic [pdq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pdq_pkg::*;

  localparam int CB = CURRENT_BITS;
  localparam int AB = ANGLE_BITS;
  localparam int XW = CURRENT_BITS + 16;

  // input word fields
  logic signed [CB-1:0] phase_a, phase_b, phase_c;
  logic        [AB-1:0] elec_angle;

  assign phase_a    = in_tdata[CB-1:0];
  assign phase_b    = in_tdata[2*CB-1:CB];
  assign phase_c    = in_tdata[3*CB-1:2*CB];
  assign elec_angle = in_tdata[3*CB+AB-1:3*CB];

  // chain links, entry 0 from the front end
  logic                 cv    [0:STEPS];
  logic                 cr    [0:STEPS];
  logic signed [XW-1:0] cx    [0:STEPS];
  logic signed [XW-1:0] cy    [0:STEPS];
  logic        [31:0]   cz    [0:STEPS];

  pdq_clarke #(
    .CB (CB),
    .AB (AB),
    .XW (XW)
  ) u_clarke (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .phase_a    (phase_a),
    .phase_b    (phase_b),
    .phase_c    (phase_c),
    .elec_angle (elec_angle),
    .out_valid  (cv[0]),
    .out_ready  (cr[0]),
    .x_out      (cx[0]),
    .y_out      (cy[0]),
    .z_out      (cz[0])
  );

  // rotation chain
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    pdq_cordic_cell #(
      .XW   (XW),
      .STEP (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[i]),
      .in_ready  (cr[i]),
      .x_in      (cx[i]),
      .y_in      (cy[i]),
      .z_in      (cz[i]),
      .out_valid (cv[i+1]),
      .out_ready (cr[i+1]),
      .x_out     (cx[i+1]),
      .y_out     (cy[i+1]),
      .z_out     (cz[i+1])
    );
  end

  // residual angle of the last cell is not needed
  logic signed [OUT_W-1:0] current_d, current_q;

  pdq_scale #(
    .XW (XW)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv[STEPS]),
    .in_ready  (cr[STEPS]),
    .x_in      (cx[STEPS]),
    .y_in      (cy[STEPS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .current_d (current_d),
    .current_q (current_q)
  );

  assign out_tdata = {{(OUT_TDATA_W-2*OUT_W){1'b0}}, current_q, current_d};

`ifndef SYNTHESIS
  // input stalls only when every stage is full and the result is not taken
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled with room in the pipeline");

  // a taken result frees every stage, so input must be open
  a_take_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |-> in_tready)
    else $error("input closed while result taken");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with the last two stages empty no result can show up next cycle
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid && !u_scale.va_r) |=> !out_tvalid)
    else $error("result appeared without an item");
`endif

endmodule
